// ===== rtl/swpp_pkg.sv =====
// shared types and constants for the sliding window packet pacer
`default_nettype none
package swpp_pkg;

    localparam int TIME_W  = 63;
    localparam int CFG_W   = 32;
    localparam int CFG_AW  = 2;
    localparam int LIMIT_W = 7;
    localparam int COUNT_OUT_W = 7;

    localparam logic [CFG_AW-1:0] CFG_WINDOW_LENGTH  = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_MAX_PER_WINDOW = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_MIN_SPACING    = 2'd2;

    localparam logic [CFG_W-1:0]   RST_WINDOW_LENGTH  = 32'd1000000000;
    localparam logic [LIMIT_W-1:0] RST_MAX_PER_WINDOW = 7'd50;
    localparam logic [CFG_W-1:0]   RST_MIN_SPACING    = 32'd20000000;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    typedef enum logic {
        ST_IDLE,
        ST_CHECK
    } t_state;

endpackage
`default_nettype wire

// ===== rtl/sliding_window_packet_pacer_top.sv =====
// top level of the sliding window packet pacer
`default_nettype none
// Send-request pacer: each accepted word carries the current time in ns and
// yields one result word (allowed, stamps in window). An item is accepted and
// then decided; before the decision one expired stamp is dropped from the ring
// at a time, since the single read port of the stamp memory delivers one stamp
// a cycle; each stamp expires once. A new request is taken only when the
// previous one is decided; a finished result waits in the output register
// without blocking the next accept. The ring needs no clearing after reset:
// only entries that were written are read.
module sliding_window_packet_pacer_top #(
    parameter int RING_DEPTH = 64
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [swpp_pkg::CFG_AW-1:0]     i_cfg_addr,
    input  wire logic [swpp_pkg::CFG_W-1:0]      i_cfg_data,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic [swpp_pkg::TIME_W-1:0]     i_now_time,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic                                 o_allowed,
    output logic [swpp_pkg::COUNT_OUT_W-1:0]     o_in_window
);
    import swpp_pkg::*;

    localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CW = $clog2(RING_DEPTH + 1);
    localparam int XW = (CW > LIMIT_W) ? CW : LIMIT_W;
    localparam logic [AW:0]   DEPTH_A = (AW + 1)'(RING_DEPTH);
    localparam logic [CW:0]   DEPTH_S = (CW + 1)'(RING_DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(RING_DEPTH);

    // configuration
    logic [CFG_W-1:0]   r_win;
    logic [LIMIT_W-1:0] r_max;
    logic [CFG_W-1:0]   r_spacing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win     <= RST_WINDOW_LENGTH;
            r_max     <= RST_MAX_PER_WINDOW;
            r_spacing <= RST_MIN_SPACING;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_WINDOW_LENGTH:  r_win     <= i_cfg_data;
                CFG_MAX_PER_WINDOW: r_max     <= i_cfg_data[LIMIT_W-1:0];
                CFG_MIN_SPACING:    r_spacing <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // pacer state
    t_state            r_state, n_state;
    logic [AW-1:0]     r_head, n_head;
    logic [CW-1:0]     r_count, n_count;
    logic [TIME_W-1:0] r_next_allowed, n_next_allowed;
    logic [TIME_W-1:0] r_now;
    logic              r_out_valid, n_out_valid;
    logic              r_allowed, n_allowed;
    logic [COUNT_OUT_W-1:0] r_in_window, n_in_window;

    logic              ring_we;
    logic [AW-1:0]     ring_waddr;
    logic [TIME_W-1:0] rd_stamp;

    logic              in_fire;
    logic              out_free;
    logic              early;
    logic              evict;
    logic              admit;
    logic [TIME_W:0]   stamp_end;
    logic [TIME_W:0]   spaced;
    logic [AW:0]       head_inc;
    logic [CW:0]       slot_sum;
    logic [XW-1:0]     count_x;

    assign in_fire  = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;

    assign early     = r_now < r_next_allowed;
    assign stamp_end = {1'b0, rd_stamp} + {{(TIME_W + 1 - CFG_W){1'b0}}, r_win};
    assign evict     = (r_count != '0) && (stamp_end < {1'b0, r_now});
    assign admit     = (XW'(r_count) < XW'(r_max)) && (r_count < DEPTH_C);
    assign spaced    = {1'b0, r_now} + {{(TIME_W + 1 - CFG_W){1'b0}}, r_spacing};
    assign head_inc  = {1'b0, r_head} + (AW + 1)'(1);
    assign slot_sum  = {{(CW + 1 - AW){1'b0}}, r_head} + {1'b0, r_count};

    always_comb begin
        n_state        = r_state;
        n_head         = r_head;
        n_count        = r_count;
        n_next_allowed = r_next_allowed;
        n_out_valid    = r_out_valid && !i_out_ready;
        n_allowed      = r_allowed;
        n_in_window    = r_in_window;
        o_in_ready     = 1'b0;
        ring_we        = 1'b0;
        ring_waddr     = (slot_sum >= DEPTH_S) ? AW'(slot_sum - DEPTH_S) : AW'(slot_sum);
        count_x        = XW'(r_count);
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (!early && evict) begin
                    // drop the oldest stamp, its successor is read meanwhile
                    n_head  = (head_inc == DEPTH_A) ? '0 : head_inc[AW-1:0];
                    n_count = r_count - CW'(1);
                end else if (out_free) begin
                    n_state     = ST_IDLE;
                    n_out_valid = 1'b1;
                    n_allowed   = !early && admit;
                    if (!early && admit) begin
                        ring_we        = 1'b1;
                        n_count        = r_count + CW'(1);
                        n_next_allowed = spaced[TIME_W] ? TIME_MAX : spaced[TIME_W-1:0];
                    end
                    count_x     = XW'(n_count);
                    n_in_window = count_x[COUNT_OUT_W-1:0];
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_head         <= '0;
            r_count        <= '0;
            r_next_allowed <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_head         <= n_head;
            r_count        <= n_count;
            r_next_allowed <= n_next_allowed;
            r_out_valid    <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_now <= i_now_time;
        end
        r_allowed   <= n_allowed;
        r_in_window <= n_in_window;
    end

    // read address follows the next head, so the oldest stamp is always ready
    swpp_ring #(
        .DEPTH (RING_DEPTH),
        .AW    (AW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ring_we),
        .i_waddr (ring_waddr),
        .i_wdata (r_now),
        .i_raddr (n_head),
        .o_rdata (rd_stamp)
    );

    assign o_out_valid = r_out_valid;
    assign o_allowed   = r_allowed;
    assign o_in_window = r_in_window;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("stamp count beyond ring depth");

    a_head_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_head} < DEPTH_A)
        else $error("ring head beyond ring depth");

    a_admit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ring_we |=> (r_count == $past(r_count) + CW'(1)) && o_out_valid && o_allowed)
        else $error("admitted word not recorded");

endmodule
`default_nettype wire

// ===== rtl/swpp_ring.sv =====
// stamp ring memory, one write port and one registered read port
`default_nettype none
module swpp_ring #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_we,
    input  wire logic [AW-1:0]             i_waddr,
    input  wire logic [swpp_pkg::TIME_W-1:0] i_wdata,
    input  wire logic [AW-1:0]             i_raddr,
    output logic      [swpp_pkg::TIME_W-1:0] o_rdata
);
    import swpp_pkg::*;

    logic [TIME_W-1:0] r_mem [DEPTH];
    logic [TIME_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== test/sliding_window_packet_pacer_top_test.sv =====
// testbench for the sliding window packet pacer: random traffic checked against a predictor
`timescale 1ns / 100ps

module sliding_window_packet_pacer_top_test;
    import swpp_pkg::*;

    localparam int RING_SLOTS  = 64;
    localparam int CYCLE_LIMIT = 500000;

    typedef struct packed {
        logic                   allowed;
        logic [COUNT_OUT_W-1:0] in_window;
    } t_pace_verdict;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_AW-1:0]    i_cfg_addr = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic [TIME_W-1:0]    i_now_time = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic                 o_allowed;
    logic [COUNT_OUT_W-1:0] o_in_window;

    sliding_window_packet_pacer_top #(
        .RING_DEPTH(RING_SLOTS)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_now_time  (i_now_time),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_allowed   (o_allowed),
        .o_in_window (o_in_window)
    );

    // pacer state as the predictor sees it
    logic [TIME_W-1:0]  stamp_log [RING_SLOTS];
    logic [5:0]         log_head = '0;
    logic [LIMIT_W-1:0] log_count = '0;
    logic [TIME_W-1:0]  admit_after = '0;
    logic [CFG_W-1:0]   cfg_window = RST_WINDOW_LENGTH;
    logic [LIMIT_W-1:0] cfg_limit = RST_MAX_PER_WINDOW;
    logic [CFG_W-1:0]   cfg_spacing = RST_MIN_SPACING;

    logic [TIME_W-1:0] request_q [$];
    t_pace_verdict     verdict_q [$];
    int                outstanding = 0;
    int                fault_count = 0;
    int                cycle_count = 0;

    bit req_taken = 1'b0;
    bit out_taken = 1'b0;
    bit send_calm = 1'b0;
    bit recv_calm = 1'b0;
    int send_wait = 0;
    int recv_wait = 0;
    int ready_hold = 0;

    logic [TIME_W-1:0] stamp_now = '0;

    function automatic t_pace_verdict pace_request(input logic [TIME_W-1:0] now);
        t_pace_verdict     v;
        logic [63:0]       reach;
        logic [LIMIT_W-1:0] cap;
        logic [5:0]        slot;
        v.allowed = 1'b0;
        if (now >= admit_after) begin
            // expire oldest stamps that fell out of the window
            while (log_count != 0 &&
                   ({1'b0, stamp_log[log_head]} + 64'(cfg_window)) < {1'b0, now}) begin
                log_head = log_head + 6'd1;
                log_count = log_count - 7'd1;
            end
            cap = (cfg_limit > RING_SLOTS) ? LIMIT_W'(RING_SLOTS) : cfg_limit;
            if (log_count < cap) begin
                slot = log_head + log_count[5:0];
                stamp_log[slot] = now;
                log_count = log_count + 7'd1;
                reach = {1'b0, now} + 64'(cfg_spacing);
                admit_after = (reach > {1'b0, TIME_MAX}) ? TIME_MAX : reach[TIME_W-1:0];
                v.allowed = 1'b1;
            end
        end
        v.in_window = log_count;
        return v;
    endfunction

    task automatic queue_request(input logic [TIME_W-1:0] t);
        request_q.insert(request_q.size(), t);
        outstanding++;
    endtask

    task automatic wait_idle();
        while (outstanding != 0 || verdict_q.size() != 0)
            @(negedge i_clk);
        // decide latency plus a margin for eviction cycles
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_W-1:0] val);
        wait_idle();
        case (idx)
            CFG_WINDOW_LENGTH:  cfg_window = val;
            CFG_MAX_PER_WINDOW: cfg_limit = val[LIMIT_W-1:0];
            CFG_MIN_SPACING:    cfg_spacing = val;
            default: ;
        endcase
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_phase(input int n, input logic [CFG_W-1:0] win,
                             input logic [LIMIT_W-1:0] lim,
                             input logic [CFG_W-1:0] spc, input int hold);
        logic [63:0]        d;
        logic [LIMIT_W-1:0] cap;
        int                 k;
        write_reg(CFG_WINDOW_LENGTH, win);
        write_reg(CFG_MAX_PER_WINDOW, CFG_W'(lim));
        write_reg(CFG_MIN_SPACING, spc);
        @(posedge i_clk);
        send_calm = ($urandom_range(0, 2) == 0);
        recv_calm = ($urandom_range(0, 2) == 0);
        ready_hold = hold;
        cap = (lim == 0) ? 7'd1 : ((lim > RING_SLOTS) ? LIMIT_W'(RING_SLOTS) : lim);
        for (k = 0; k < n; k++) begin
            d = 64'd0;
            case ($urandom_range(0, 9))
                0: d = 64'd0;
                1: d = 64'($urandom_range(0, 3));
                2, 3: d = 64'(spc);
                4: d = 64'(spc) + 64'($urandom_range(1, 3));
                5: d = (spc == 0) ? 64'd0 : 64'(spc) - 64'd1;
                6, 7: d = 64'(win) / 64'(cap) + 64'($urandom_range(0, 2));
                8: d = 64'(win) + 64'd1 + 64'($urandom_range(0, 1));
                default: begin
                    // a step back in time
                    d = 64'($urandom_range(1, 4));
                    stamp_now = (stamp_now > d[TIME_W-1:0]) ? stamp_now - d[TIME_W-1:0] : '0;
                    d = 64'd0;
                end
            endcase
            stamp_now = stamp_now + d[TIME_W-1:0];
            queue_request(stamp_now);
        end
    endtask

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL sliding_window_packet_pacer_top");
            $finish;
        end
    end

    // sender: one word per request, random gap after each accept (none in a calm phase)
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_in_valid || req_taken) begin
                if (req_taken) begin
                    req_taken = 1'b0;
                    send_wait = send_calm ? 0 : $urandom_range(0, 12);
                end
                if (send_wait > 0) begin
                    send_wait--;
                    i_in_valid <= 1'b0;
                end else if (request_q.size() != 0) begin
                    i_in_valid <= 1'b1;
                    i_now_time <= request_q[0];
                    request_q.delete(0);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: random stall per result word (none in a calm phase), plus long hold-offs on request
    always @(negedge i_clk) begin
        if (out_taken) begin
            out_taken = 1'b0;
            recv_wait = recv_calm ? 0 : $urandom_range(0, 12);
        end
        if (ready_hold > 0) begin
            ready_hold--;
            i_out_ready <= 1'b0;
        end else if (recv_wait > 0) begin
            recv_wait--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // monitor: predict on accept, compare on result
    always @(posedge i_clk) begin
        t_pace_verdict want;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                verdict_q.insert(verdict_q.size(), pace_request(i_now_time));
                outstanding--;
                req_taken = 1'b1;
            end
            if (o_out_valid && i_out_ready) begin
                out_taken = 1'b1;
                if (verdict_q.size() == 0) begin
                    fault_count++;
                    if (fault_count <= 10)
                        $display("unexpected result word: allowed %0b in_window %0d",
                                 o_allowed, o_in_window);
                end else begin
                    want = verdict_q[0];
                    verdict_q.delete(0);
                    if (o_allowed !== want.allowed || o_in_window !== want.in_window) begin
                        fault_count++;
                        if (fault_count <= 10)
                            $display("mismatch: expected allowed %0b in_window %0d, got %0b %0d",
                                     want.allowed, want.in_window, o_allowed, o_in_window);
                    end
                end
            end
        end
    end

    initial begin
        logic [TIME_W-1:0] base;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings: first admit, early request, admit on spacing
        queue_request(63'd0);
        queue_request(63'd19_999_999);
        queue_request(63'd20_000_000);

        base = 63'd40_000_000;
        write_reg(CFG_WINDOW_LENGTH, 32'd100);
        write_reg(CFG_MAX_PER_WINDOW, 32'd3);
        write_reg(CFG_MIN_SPACING, 32'd10);
        queue_request(base);
        queue_request(base + 63'd5);
        queue_request(base + 63'd10);
        queue_request(base + 63'd20);
        queue_request(base + 63'd30);
        queue_request(base + 63'd101);
        queue_request(base + 63'd111);
        queue_request(base + 63'd90);

        // zero window, no spacing
        write_reg(CFG_MIN_SPACING, 32'd0);
        write_reg(CFG_WINDOW_LENGTH, 32'd0);
        queue_request(base + 63'd200);
        queue_request(base + 63'd200);
        queue_request(base + 63'd200);
        queue_request(base + 63'd201);

        // zero limit
        write_reg(CFG_MAX_PER_WINDOW, 32'd0);
        queue_request(base + 63'd300);
        queue_request(base + 63'd300);
        stamp_now = base + 63'd300;

        run_phase(45, 32'd1000, 7'd5, 32'd10, 300);
        run_phase(45, 32'd0, 7'd3, 32'd0, 0);
        run_phase(60, 32'hFFFF_FFFF, 7'd127, 32'd0, 400);
        run_phase(45, 32'hFFFF_FFFF, 7'd64, 32'hFFFF_FFFF, 0);
        run_phase(20, 32'd10, 7'd0, 32'd1, 0);
        run_phase(40, 32'd1, 7'd1, 32'd0, 0);
        run_phase(50, 32'($urandom_range(1, 2000)), 7'($urandom_range(1, 64)),
                  32'($urandom_range(0, 100)), 0);
        run_phase(50, 32'($urandom_range(1, 2000)), 7'($urandom_range(1, 64)),
                  32'($urandom_range(0, 100)), 0);

        // high times, then saturation of the next admit time
        wait_idle();
        stamp_now = {1'b1, 6'($urandom), 32'($urandom), 24'd0};
        run_phase(45, 32'd2000, 7'd8, 32'd100, 0);
        write_reg(CFG_MAX_PER_WINDOW, 32'd64);
        queue_request(TIME_MAX - 63'd3);
        queue_request(TIME_MAX - 63'd1);
        queue_request(TIME_MAX);
        queue_request(TIME_MAX);

        wait_idle();
        repeat (16) @(posedge i_clk);
        if (fault_count == 0) begin
            $display("PASS sliding_window_packet_pacer_top");
        end else begin
            $display("FAIL sliding_window_packet_pacer_top");
        end
        $finish;
    end

endmodule
